// ===== src/lcdrb_pkg.sv =====
// shared types and constants of the lcd controller register block
`timescale 1ns / 1ps

package lcdrb_pkg;

   // transaction kinds
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // word addresses (byte offset >> 2)
   localparam logic [9:0] WORD_TIMING0  = 10'd0;
   localparam logic [9:0] WORD_TIMING1  = 10'd1;
   localparam logic [9:0] WORD_TIMING2  = 10'd2;
   localparam logic [9:0] WORD_TIMING3  = 10'd3;
   localparam logic [9:0] WORD_UPBASE   = 10'd4;
   localparam logic [9:0] WORD_LPBASE   = 10'd5;
   localparam logic [9:0] WORD_SLOT_A   = 10'd6;
   localparam logic [9:0] WORD_SLOT_B   = 10'd7;
   localparam logic [9:0] WORD_RIS      = 10'd8;
   localparam logic [9:0] WORD_MIS      = 10'd9;
   localparam logic [9:0] WORD_ICR      = 10'd10;
   localparam logic [9:0] WORD_UPCURR   = 10'd11;
   localparam logic [9:0] WORD_LPCURR   = 10'd12;
   localparam logic [9:0] WORD_ID_FIRST = 10'h3f8;

   // palette window is words 0x080..0x0ff
   localparam logic [2:0] PAL_WORD_TOP = 3'b001;

   // control word bits
   localparam int CR_EN_BIT  = 0;
   localparam int CR_PWR_BIT = 11;

   // variant codes
   localparam logic [1:0] VARIANT_BASIC = 2'd0;
   localparam logic [1:0] VARIANT_EXT   = 2'd2;

   localparam logic [7:0] ID_BASIC [0:7] =
      '{8'h10, 8'h11, 8'h04, 8'h00, 8'h0d, 8'hf0, 8'h05, 8'hb1};
   localparam logic [7:0] ID_EXT [0:7] =
      '{8'h11, 8'h11, 8'h24, 8'h00, 8'h0d, 8'hf0, 8'h05, 8'hb1};

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] byte_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
      logic [10:0] width_pixels;
      logic [10:0] height_lines;
      logic [2:0]  pixel_format;
      logic        display_on;
      logic        bad_access;
   } rsp_type;

endpackage

// ===== src/lcd_controller_register_block.sv =====
// top level of the lcd controller register block
`timescale 1ns / 1ps

// register file of a color lcd controller
// req channel: one transaction per item, a bus read, a bus write or a
//   vertical-blank tick, with byte offset and write data
// rsp channel: one transaction per request with read data, irq, active
//   width and height, pixel format, display-on and a bad-access flag;
//   all status outputs reflect state after the request took effect
// csr port: csr_write_enable/csr_write_data set the variant (basic,
//   board, extended); write only while no request is in flight
// pipeline: an accepted request is registered in the input stage, then its
//   response in the response register; one request per cycle while the
//   response is not stalled; the input stage and the response register are
//   separate, so a new request is taken while a response waits; the palette
//   ram read is issued at acceptance, so its data is ready in the input stage
// receiver stall: the response register holds, the input stage holds
//   one more request, then req_ready drops
// reset: all architectural registers, status flags, width/height and
//   variant clear; palette entries read as zero until written (valid bit per entry)
module lcd_controller_register_block #(
   parameter int PALETTE_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lcdrb_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lcdrb_pkg::rsp_type rsp_payload,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_write_data
);

   localparam int PalIdxW = $clog2(PALETTE_DEPTH);

   // handshake and pipeline control
   logic               req_fire;
   logic               s1_adv;
   logic               s1_valid_ff;
   lcdrb_pkg::req_type s1_req_ff;
   logic               rsp_valid_ff;
   lcdrb_pkg::rsp_type rsp_ff;
   lcdrb_pkg::rsp_type rsp_in;

   // configuration
   logic [1:0] variant_ff;
   logic       swapped;
   logic       ext_id;

   // architectural registers
   logic [31:0] timing_ff [4];
   logic [31:0] timing_in [4];
   logic [31:0] upper_ff, upper_in;
   logic [31:0] lower_ff, lower_in;
   logic [31:0] control_ff, control_in;
   logic [31:0] mask_ff, mask_in;
   logic [1:0]  status_ff, status_in;
   logic [10:0] columns_ff, columns_in;
   logic [10:0] lines_ff, lines_in;

   // decode of the request in the input stage
   logic [9:0]  word;
   logic        is_id;
   logic        is_pal;
   logic [2:0]  id_idx;
   logic [7:0]  id_byte;
   logic [31:0] pal_rd_data;
   logic        pal_wr;
   logic        disp_on_cur;
   logic [31:0] wdata;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign swapped = (variant_ff != lcdrb_pkg::VARIANT_BASIC);
   assign ext_id  = (variant_ff >= lcdrb_pkg::VARIANT_EXT);

   assign word    = s1_req_ff.byte_offset[11:2];
   assign wdata   = s1_req_ff.write_data;
   assign is_id   = (word >= lcdrb_pkg::WORD_ID_FIRST);
   assign is_pal  = (word[9:7] == lcdrb_pkg::PAL_WORD_TOP);
   assign id_idx  = word[2:0];
   assign id_byte = ext_id ? lcdrb_pkg::ID_EXT[id_idx] : lcdrb_pkg::ID_BASIC[id_idx];
   assign disp_on_cur = control_ff[lcdrb_pkg::CR_EN_BIT] && control_ff[lcdrb_pkg::CR_PWR_BIT];

   // palette ram: read at acceptance, written when the input stage retires
   lcdrb_palette #(
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_idx  (req_payload.byte_offset[2 +: PalIdxW]),
      .wr_en   (s1_adv && pal_wr),
      .wr_idx  (s1_req_ff.byte_offset[2 +: PalIdxW]),
      .wr_data (wdata),
      .rd_data (pal_rd_data)
   );

   // single-pass decode and update
   always_comb begin
      timing_in  = timing_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      control_in = control_ff;
      mask_in    = mask_ff;
      status_in  = status_ff;
      columns_in = columns_ff;
      lines_in   = lines_ff;
      pal_wr     = 1'b0;
      rsp_in     = '0;

      unique case (s1_req_ff.func)
         lcdrb_pkg::FUNC_READ: begin
            if (is_id) begin
               rsp_in.read_data = {24'd0, id_byte};
            end else if (is_pal) begin
               rsp_in.read_data = pal_rd_data;
            end else begin
               unique case (word)
                  lcdrb_pkg::WORD_TIMING0: rsp_in.read_data = timing_ff[0];
                  lcdrb_pkg::WORD_TIMING1: rsp_in.read_data = timing_ff[1];
                  lcdrb_pkg::WORD_TIMING2: rsp_in.read_data = timing_ff[2];
                  lcdrb_pkg::WORD_TIMING3: rsp_in.read_data = timing_ff[3];
                  lcdrb_pkg::WORD_UPBASE,
                  lcdrb_pkg::WORD_UPCURR:  rsp_in.read_data = upper_ff;
                  lcdrb_pkg::WORD_LPBASE,
                  lcdrb_pkg::WORD_LPCURR:  rsp_in.read_data = lower_ff;
                  lcdrb_pkg::WORD_SLOT_A:  rsp_in.read_data = swapped ? control_ff : mask_ff;
                  lcdrb_pkg::WORD_SLOT_B:  rsp_in.read_data = swapped ? mask_ff : control_ff;
                  lcdrb_pkg::WORD_RIS:     rsp_in.read_data = {28'd0, status_ff, 2'b00};
                  lcdrb_pkg::WORD_MIS:
                     rsp_in.read_data = {28'd0, status_ff & mask_ff[3:2], 2'b00};
                  default:                 rsp_in.bad_access = 1'b1;
               endcase
            end
         end
         lcdrb_pkg::FUNC_WRITE: begin
            if (is_pal) begin
               pal_wr = 1'b1;
            end else begin
               unique case (word)
                  lcdrb_pkg::WORD_TIMING0: begin
                     timing_in[0] = wdata;
                     // ((t0 & 0xfc) + 4) * 4
                     columns_in = {({1'b0, wdata[7:2]} + 7'd1), 4'b0000};
                  end
                  lcdrb_pkg::WORD_TIMING1: begin
                     timing_in[1] = wdata;
                     lines_in = {1'b0, wdata[9:0]} + 11'd1;
                  end
                  lcdrb_pkg::WORD_TIMING2: timing_in[2] = wdata;
                  lcdrb_pkg::WORD_TIMING3: timing_in[3] = wdata;
                  lcdrb_pkg::WORD_UPBASE:  upper_in = wdata;
                  lcdrb_pkg::WORD_LPBASE:  lower_in = wdata;
                  lcdrb_pkg::WORD_SLOT_A: begin
                     if (swapped) begin
                        control_in = wdata;
                     end else begin
                        mask_in = wdata;
                     end
                  end
                  lcdrb_pkg::WORD_SLOT_B: begin
                     if (swapped) begin
                        mask_in = wdata;
                     end else begin
                        control_in = wdata;
                     end
                  end
                  // write-one-to-clear on status bits 3:2
                  lcdrb_pkg::WORD_ICR: status_in = status_ff & ~wdata[3:2];
                  default:             rsp_in.bad_access = 1'b1;
               endcase
            end
         end
         lcdrb_pkg::FUNC_TICK: begin
            if (disp_on_cur) begin
               status_in = 2'b11;
            end
         end
         default: begin
         end
      endcase

      // status outputs after the update
      rsp_in.irq          = |(status_in & mask_in[3:2]);
      rsp_in.width_pixels = columns_in;
      rsp_in.height_lines = lines_in;
      rsp_in.pixel_format = control_in[3:1];
      rsp_in.display_on   = control_in[lcdrb_pkg::CR_EN_BIT]
                            && control_in[lcdrb_pkg::CR_PWR_BIT];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         variant_ff   <= lcdrb_pkg::VARIANT_BASIC;
         timing_ff    <= '{default: 32'd0};
         upper_ff     <= 32'd0;
         lower_ff     <= 32'd0;
         control_ff   <= 32'd0;
         mask_ff      <= 32'd0;
         status_ff    <= 2'b00;
         columns_ff   <= 11'd0;
         lines_ff     <= 11'd0;
      end else begin
         if (csr_write_enable) begin
            variant_ff <= csr_write_data;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            timing_ff    <= timing_in;
            upper_ff     <= upper_in;
            lower_ff     <= lower_in;
            control_ff   <= control_in;
            mask_ff      <= mask_in;
            status_ff    <= status_in;
            columns_ff   <= columns_in;
            lines_ff     <= lines_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_payload;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // a tick with the display off leaves the status flags alone
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_req_ff.func == lcdrb_pkg::FUNC_TICK && !disp_on_cur)
      |=> status_ff == $past(status_ff))
      else $error("status changed on tick with display off");

   // a request waiting behind a stalled response is not dropped
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("input stage lost a request during stall");

   // a bad access never returns data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bad_access) |-> rsp_ff.read_data == 32'd0)
      else $error("bad access with nonzero read data");

   // active width is always a multiple of sixteen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.width_pixels[3:0] == 4'd0)
      else $error("width not a multiple of sixteen");

endmodule

// ===== src/lcdrb_palette.sv =====
// palette ram with per-entry valid bits and write-to-read forwarding
`timescale 1ns / 1ps

module lcdrb_palette #(
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_idx,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_idx,
   input  logic [31:0]              wr_data,
   output logic [31:0]              rd_data
);

   logic [31:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [31:0]      q_ff;
   logic             vld_ff;
   logic             fwd_ff;
   logic [31:0]      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_idx];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            vld_ff <= valid_ff[rd_idx];
            // same-cycle write to the address being read
            fwd_ff <= wr_en && (wr_idx == rd_idx);
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (vld_ff ? q_ff : 32'd0);

endmodule
